// ----- rtl/relocation_delta_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the relocation delta encoder RTL.
// ----------------------------------------------------------------------------
`ifndef RELOCATION_DELTA_ENCODER_MACROS_SVH
`define RELOCATION_DELTA_ENCODER_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define RDE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// Types and constants for the relocation delta encoder.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Widest site offset the ports carry
  localparam int unsigned SITE_W    = 13;
  // Delta field width in a queued command
  localparam int unsigned DELTA_W   = 13;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
  localparam int unsigned SKIP_STEP  = 254;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_SEG   = 1'b1;

  localparam logic [2:0] HIGH_TYPE_RST = 3'd2;
  localparam logic [4:0] EXT_SEG_RST   = 5'd0;

  // Command queue depth and pointer width
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic        table_start;
    logic [12:0] site_offset;
    logic [2:0]  reloc_type;
    logic [4:0]  segment_id;
    logic [7:0]  high_low_byte;
    logic [31:0] symbol_index;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_entry;
  } out_beat_t;

  // One classified entry, ready to be serialized
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [7:0]         type_seg;
    logic [7:0]         extra;
    logic [31:0]        symbol_index;
    logic               has_high;
    logic               has_ext;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ESC,
    B_DELTA,
    B_TSEG,
    B_EXTRA,
    B_SYM
  } back_state_t;

endpackage

// ----- rtl/rde_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_front
// Accepts entries, tracks the running offset, drops sites that do not move
// forward and queues a classified command for each kept entry.
// ----------------------------------------------------------------------------
module rde_front #(
  parameter int unsigned OFFSET_BITS = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rde_pkg::in_beat_t              in_data,
  input  logic                           cfg_we,
  input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                           q_push,
  output rde_pkg::cmd_t                  q_cmd,
  input  rde_pkg::q_status_t             q_status
);

  logic [OFFSET_BITS-1:0] running_r, running_nxt;
  logic [2:0]             high_type_r, high_type_nxt;
  logic [4:0]             ext_seg_r, ext_seg_nxt;
  logic                   accept;
  logic [OFFSET_BITS-1:0] site;
  logic [OFFSET_BITS-1:0] base;
  logic                   keep;

  // Stall whenever the queue cannot take a command
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Classify the entry against the running offset
  assign site = in_data.site_offset[OFFSET_BITS-1:0];
  assign base = in_data.table_start ? '0 : running_r;
  assign keep = site > base;

  assign q_push              = accept && keep;
  assign q_cmd.delta         = rde_pkg::DELTA_W'(site - base);
  assign q_cmd.type_seg      = {in_data.reloc_type, in_data.segment_id};
  assign q_cmd.extra         = in_data.high_low_byte;
  assign q_cmd.symbol_index  = in_data.symbol_index;
  assign q_cmd.has_high      = in_data.reloc_type == high_type_r;
  assign q_cmd.has_ext       = in_data.segment_id == ext_seg_r;

  // Advance the running offset; a table start clears it even on a drop
  always_comb begin
    running_nxt = running_r;
    if (accept) begin
      running_nxt = keep ? site : base;
    end
  end

  // Decode configuration writes
  always_comb begin
    high_type_nxt = high_type_r;
    ext_seg_nxt   = ext_seg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rde_pkg::REG_HIGH_TYPE: high_type_nxt = cfg_wdata[2:0];
        rde_pkg::REG_EXT_SEG:   ext_seg_nxt   = cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      high_type_r <= rde_pkg::HIGH_TYPE_RST;
      ext_seg_r   <= rde_pkg::EXT_SEG_RST;
    end else begin
      running_r   <= running_nxt;
      high_type_r <= high_type_nxt;
      ext_seg_r   <= ext_seg_nxt;
    end
  end

endmodule

// ----- rtl/rde_fifo.sv -----
`timescale 1ns / 1ps
`include "relocation_delta_encoder_macros.svh"
// ----------------------------------------------------------------------------
// rde_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rde_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rde_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output rde_pkg::cmd_t      pop_cmd,
  output rde_pkg::q_status_t status
);

  rde_pkg::cmd_t                 mem_r [rde_pkg::QUEUE_DEPTH];
  logic [rde_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rde_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rde_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign status.full  = count_r == rde_pkg::QCNT_W'(rde_pkg::QUEUE_DEPTH);
  assign status.empty = count_r == '0;
  assign pop_cmd      = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `RDE_ASSERT(a_no_push_full, clk, rst_n, push |-> !status.full, "push into full queue")
  `RDE_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !status.empty, "pop from empty queue")
  `RDE_ASSERT(a_count_bound, clk, rst_n, count_r <= rde_pkg::QCNT_W'(rde_pkg::QUEUE_DEPTH), "queue count over depth")

endmodule

// ----- rtl/rde_back.sv -----
`timescale 1ns / 1ps
`include "relocation_delta_encoder_macros.svh"
// ----------------------------------------------------------------------------
// rde_back
// Serializes one queued command into escape, delta, type/segment and optional
// extra and index bytes, one beat per unstalled cycle to a registered output.
// ----------------------------------------------------------------------------
module rde_back #(
  parameter int unsigned OFFSET_BITS = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               q_pop,
  input  rde_pkg::cmd_t      q_cmd,
  input  rde_pkg::q_status_t q_status,
  output logic               out_valid,
  input  logic               out_stall,
  output rde_pkg::out_beat_t out_data
);

  localparam logic [OFFSET_BITS-1:0] SKIP = OFFSET_BITS'(rde_pkg::SKIP_STEP);

  rde_pkg::back_state_t   state_r, state_nxt;
  rde_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [OFFSET_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rde_pkg::out_beat_t     out_data_r, out_data_nxt;
  logic                   can_emit;
  logic [OFFSET_BITS-1:0] rem_sub;
  logic [OFFSET_BITS-1:0] load_delta;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_emit  = !out_valid_r || !out_stall;
  assign rem_sub   = rem_r - SKIP;
  assign load_delta = q_cmd.delta[OFFSET_BITS-1:0];

  // Sequence the bytes of the current entry
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    unique case (state_r)
      rde_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          rem_nxt   = load_delta;
          idx_nxt   = '0;
          state_nxt = (load_delta > SKIP) ? rde_pkg::B_ESC : rde_pkg::B_DELTA;
        end
      end
      rde_pkg::B_ESC: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: rde_pkg::ESCAPE_BYTE, last_of_entry: 1'b0};
          rem_nxt       = rem_sub;
          state_nxt     = (rem_sub > SKIP) ? rde_pkg::B_ESC : rde_pkg::B_DELTA;
        end
      end
      rde_pkg::B_DELTA: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: rem_r[7:0], last_of_entry: 1'b0};
          state_nxt     = rde_pkg::B_TSEG;
        end
      end
      rde_pkg::B_TSEG: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: cmd_r.type_seg,
                            last_of_entry: !cmd_r.has_high && !cmd_r.has_ext};
          if (cmd_r.has_high) begin
            state_nxt = rde_pkg::B_EXTRA;
          end else if (cmd_r.has_ext) begin
            state_nxt = rde_pkg::B_SYM;
          end else begin
            state_nxt = rde_pkg::B_IDLE;
          end
        end
      end
      rde_pkg::B_EXTRA: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: cmd_r.extra, last_of_entry: !cmd_r.has_ext};
          state_nxt     = cmd_r.has_ext ? rde_pkg::B_SYM : rde_pkg::B_IDLE;
        end
      end
      rde_pkg::B_SYM: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: 8'(cmd_r.symbol_index >> {idx_r, 3'b000}),
                            last_of_entry: idx_r == 2'd3};
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == 2'd3) begin
            state_nxt = rde_pkg::B_IDLE;
          end
        end
      end
      default: state_nxt = rde_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rde_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  `RDE_ASSERT(a_esc_gap, clk, rst_n, (state_r == rde_pkg::B_ESC) |-> (rem_r > SKIP), "escape with small gap")
  `RDE_ASSERT(a_sym_ext, clk, rst_n, (state_r == rde_pkg::B_SYM) |-> cmd_r.has_ext, "index bytes without external segment")
  `RDE_ASSERT(a_delta_nz, clk, rst_n, (state_r == rde_pkg::B_DELTA) |-> (rem_r != '0), "zero delta byte")

endmodule

// ----- rtl/relocation_delta_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relocation_delta_encoder
// Encodes relocation entries into a delta-coded relocation byte stream.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Beat
//  in_      input      in_valid / in_stall  one relocation entry
//  out_     output     out_valid / out_stall one stream byte, last flag
//  cfg_     input      cfg_we               one register write
//
//  An entry with k escape bytes yields k+2 to k+7 output bytes, after the
//  sequencer loads it from the command queue in its idle state; the output
//  sequencer emitting one byte per cycle while out_stall is low sets the rate.
//  Dropped entries are consumed from the input and produce nothing.
//  Reset clears the running offset, empties the queue and restores
//  high_type_code to 2 and external_segment_code to 0.
//  out_stall holds the output register; the two-entry queue then fills
//  and raises in_stall.
// ----------------------------------------------------------------------------
module relocation_delta_encoder #(
  parameter int unsigned OFFSET_BITS = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rde_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rde_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]      cfg_wdata
);

  logic               q_push;
  logic               q_pop;
  rde_pkg::cmd_t      q_in_cmd;
  rde_pkg::cmd_t      q_out_cmd;
  rde_pkg::q_status_t q_status;

  // Classify and queue entries
  rde_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd),
    .q_status  (q_status)
  );

  // Decouple front and back
  rde_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .status   (q_status)
  );

  // Serialize commands into bytes
  rde_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_cmd     (q_out_cmd),
    .q_status  (q_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb_relocation_delta_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relocation_delta_encoder
// Drives relocation entries into the delta encoder and checks each stream
// byte against a local delta-coding predictor. The run covers directed gap,
// drop and register cases, then random entry sequences under several register
// settings, with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_relocation_delta_encoder;

  localparam int unsigned PHASE_ITEMS   = 90;
  localparam int unsigned BURST_ITEMS   = 20;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SITE_MAX      = 8191;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  rde_pkg::in_beat_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  rde_pkg::out_beat_t            out_data;
  logic                          cfg_we    = 1'b0;
  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rde_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // Predictor state and pending stream bytes
  rde_pkg::out_beat_t   stream_bytes[$];
  logic [12:0]          cur_offset    = '0;
  logic [2:0]           cfg_high_type = rde_pkg::HIGH_TYPE_RST;
  logic [4:0]           cfg_ext_seg   = rde_pkg::EXT_SEG_RST;

  int unsigned          err_count  = 0;
  bit                   in_idle_en = 1'b1;
  bit                   out_idle_en = 1'b1;
  int unsigned          hold_left  = 0;
  int unsigned          stall_left = 0;

  relocation_delta_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    rde_pkg::out_beat_t beat;
    beat.out_byte      = b;
    beat.last_of_entry = 1'b0;
    stream_bytes.insert(stream_bytes.size(), beat);
  endfunction

  // Delta-code one accepted entry into the expected byte stream
  function automatic void encode_entry(input rde_pkg::in_beat_t e);
    logic [12:0] gap;
    if (e.table_start) cur_offset = '0;
    if (e.site_offset <= cur_offset) return;
    gap = e.site_offset - cur_offset;
    while (gap > rde_pkg::SKIP_STEP) begin
      queue_byte(rde_pkg::ESCAPE_BYTE);
      gap = gap - 13'(rde_pkg::SKIP_STEP);
    end
    queue_byte(gap[7:0]);
    queue_byte({e.reloc_type, e.segment_id});
    if (e.reloc_type == cfg_high_type) queue_byte(e.high_low_byte);
    if (e.segment_id == cfg_ext_seg) begin
      queue_byte(e.symbol_index[7:0]);
      queue_byte(e.symbol_index[15:8]);
      queue_byte(e.symbol_index[23:16]);
      queue_byte(e.symbol_index[31:24]);
    end
    stream_bytes[stream_bytes.size() - 1].last_of_entry = 1'b1;
    cur_offset = e.site_offset;
  endfunction

  function automatic rde_pkg::in_beat_t make_entry(input logic start, input logic [12:0] site,
                                          input logic [2:0] rtype, input logic [4:0] seg,
                                          input logic [7:0] extra, input logic [31:0] sym);
    rde_pkg::in_beat_t e;
    e.table_start   = start;
    e.site_offset   = site;
    e.reloc_type    = rtype;
    e.segment_id    = seg;
    e.high_low_byte = extra;
    e.symbol_index  = sym;
    return e;
  endfunction

  // Mostly forward steps from the current site, some drops and table restarts
  function automatic rde_pkg::in_beat_t random_entry();
    rde_pkg::in_beat_t e;
    int unsigned       pick;
    int unsigned       step;
    e = make_entry(1'b0, '0, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)), $urandom());
    if ($urandom_range(0, 3) == 0) e.reloc_type = cfg_high_type;
    if ($urandom_range(0, 3) == 0) e.segment_id = cfg_ext_seg;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      if (pick < 60)      step = $urandom_range(1, 254);
      else if (pick < 80) step = $urandom_range(255, 1500);
      else                step = $urandom_range(1501, SITE_MAX);
      if (cur_offset + step > SITE_MAX) begin
        e.table_start = 1'b1;
        e.site_offset = 13'(step);
      end else begin
        e.site_offset = 13'(cur_offset + step);
      end
    end else if (pick < 92) begin
      e.site_offset = 13'($urandom_range(0, cur_offset));
    end else begin
      e.table_start = 1'b1;
      e.site_offset = 13'($urandom_range(0, SITE_MAX));
    end
    return e;
  endfunction

  // Offer one entry, hold it until accepted, then maybe idle
  task automatic send_entry(input rde_pkg::in_beat_t e);
    int unsigned gap;
    in_data  <= e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_entry(e);
    gap = (in_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait out the stream, then let dropped entries settle
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (stream_bytes.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rde_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rde_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == rde_pkg::REG_HIGH_TYPE) cfg_high_type = val[2:0];
    else                               cfg_ext_seg   = val;
    @(posedge clk);
  endtask

  task automatic test_directed();
    // Empty gap from zero is dropped
    send_entry(make_entry(1'b0, 13'd0, 3'd1, 5'd1, 8'h00, 32'h0));
    // Smallest gap, external segment with all-ones index
    send_entry(make_entry(1'b0, 13'd1, 3'd0, 5'd0, 8'h00, 32'hFFFF_FFFF));
    // Gap of exactly one step, high type
    send_entry(make_entry(1'b0, 13'd255, 3'd2, 5'd31, 8'hFF, 32'h0));
    // One escape plus one
    send_entry(make_entry(1'b0, 13'd510, 3'd7, 5'd1, 8'h5A, 32'h0));
    // One escape plus a full step, high type and external together
    send_entry(make_entry(1'b0, 13'd1018, 3'd2, 5'd0, 8'h00, 32'h1234_5678));
    // Equal and lower sites are dropped
    send_entry(make_entry(1'b0, 13'd1018, 3'd3, 5'd3, 8'h11, 32'h0));
    send_entry(make_entry(1'b0, 13'd500, 3'd4, 5'd4, 8'h22, 32'h0));
    // Table restart on a dropped entry still clears the offset
    send_entry(make_entry(1'b1, 13'd0, 3'd5, 5'd5, 8'h33, 32'h0));
    send_entry(make_entry(1'b0, 13'd3, 3'd1, 5'd2, 8'h44, 32'h0));
    // Widest gap: the most escapes, high type and external
    send_entry(make_entry(1'b1, 13'h1FFF, 3'd2, 5'd0, 8'hA5, 32'hDEAD_BEEF));
    // Remaining types from a fresh table
    send_entry(make_entry(1'b1, 13'd2, 3'd3, 5'd16, 8'h01, 32'h0));
    send_entry(make_entry(1'b0, 13'd3, 3'd4, 5'd8, 8'h02, 32'h0));
    send_entry(make_entry(1'b0, 13'd4, 3'd5, 5'd30, 8'h03, 32'h0));
    send_entry(make_entry(1'b0, 13'd5, 3'd6, 5'd15, 8'h04, 32'h0));
    send_entry(make_entry(1'b0, 13'd509, 3'd6, 5'd0, 8'h80, 32'h8000_0001));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(rde_pkg::REG_HIGH_TYPE, 5'd7);
    write_reg(rde_pkg::REG_EXT_SEG, 5'd31);
    send_entry(make_entry(1'b1, 13'd40, 3'd7, 5'd31, 8'hC3, 32'h0102_0304));
    send_entry(make_entry(1'b0, 13'd41, 3'd2, 5'd0, 8'h3C, 32'h0));
    wait_idle();
    // Upper value bits fall outside the three-bit type register
    write_reg(rde_pkg::REG_HIGH_TYPE, 5'h18);
    write_reg(rde_pkg::REG_EXT_SEG, 5'd0);
    send_entry(make_entry(1'b0, 13'd300, 3'd0, 5'd0, 8'h7E, 32'hCAFE_F00D));
    send_entry(make_entry(1'b0, 13'd301, 3'd7, 5'd31, 8'h81, 32'h0));
    wait_idle();
  endtask

  task automatic test_random_phase(input logic [4:0] high_val, input logic [4:0] ext_val,
                                   input bit idle_en);
    rde_pkg::in_beat_t e;
    int unsigned       kept;
    write_reg(rde_pkg::REG_HIGH_TYPE, high_val);
    write_reg(rde_pkg::REG_EXT_SEG, ext_val);
    in_idle_en  = idle_en;
    out_idle_en = idle_en;
    kept = 0;
    while (kept < PHASE_ITEMS) begin
      e = random_entry();
      if (e.site_offset > (e.table_start ? 13'd0 : cur_offset)) kept++;
      send_entry(e);
    end
    wait_idle();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Hold the output long enough for the queue to fill and stall the input
  task automatic test_backpressure();
    in_idle_en = 1'b0;
    hold_left  = HOLD_CYCLES;
    repeat (BURST_ITEMS) send_entry(random_entry());
    wait_idle();
    in_idle_en = 1'b1;
  endtask

  // Output stall: long hold-off first, then random gaps
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted beat with the oldest expected byte
  always @(posedge clk) begin
    rde_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stream_bytes.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("ERROR: unexpected beat byte=%02h last=%0b",
                   out_data.out_byte, out_data.last_of_entry);
      end else begin
        want = stream_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.last_of_entry !== want.last_of_entry) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("ERROR: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                     want.out_byte, want.last_of_entry,
                     out_data.out_byte, out_data.last_of_entry);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_phase(5'd7, 5'd31, 1'b1);
    test_random_phase(5'h18, 5'd16, 1'b0);
    test_backpressure();
    test_random_phase(5'd5, 5'd0, 1'b1);
    test_random_phase({2'b00, rde_pkg::HIGH_TYPE_RST}, rde_pkg::EXT_SEG_RST, 1'b1);
    wait_idle();
    if (err_count == 0 && stream_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (stream_bytes.size() != 0)
        $display("ERROR: %0d expected bytes never arrived", stream_bytes.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #8_000_000;
    $display("ERROR: timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
